// ===== design/ocix_pkg.sv =====
// Types and constants shared by the order coordinate index unit
`default_nettype none
package ocix_pkg;

  localparam logic [2:0] REQ_APPEND  = 3'd0;
  localparam logic [2:0] REQ_REMOVE  = 3'd1;
  localparam logic [2:0] REQ_CLEAR   = 3'd2;
  localparam logic [2:0] REQ_LOAD_X  = 3'd3;
  localparam logic [2:0] REQ_LOAD_Y  = 3'd4;
  localparam logic [2:0] REQ_PERMUTE = 3'd5;
  localparam logic [2:0] REQ_LOOKUP  = 3'd6;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_MISSING  = 2'd1;
  localparam logic [1:0] STS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [9:0] vertex;
    logic [5:0] x_rank;
    logic [5:0] y_rank;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] x_value;
    logic signed [63:0] y_value;
    logic               x_present;
    logic               y_present;
  } rsp_t;

  typedef struct packed {
    logic [9:0] vertex;
    logic [5:0] x_rank;
    logic [5:0] y_rank;
  } dent_t;

  typedef enum logic [3:0] {
    C_NONE, C_SWEEP, C_ACCEPT, C_EXEC, C_GATH_A, C_GATH_B, C_GATH_C,
    C_LOAD_A, C_LOAD_B, C_CNT_A, C_CNT_B, C_PLACE, C_WR_A, C_WR_B, C_EMIT
  } cmd_e;

  typedef enum logic [3:0] {
    ST_SWEEP_RST, ST_SWEEP_CLR, ST_IDLE, ST_EXEC, ST_GATH_A, ST_GATH_B,
    ST_GATH_C, ST_LOAD_A, ST_LOAD_B, ST_CNT_A, ST_CNT_B, ST_PLACE,
    ST_WR_A, ST_WR_B, ST_DONE
  } state_e;

  typedef struct packed {
    logic sweep_last;
    logic is_clear;
    logic commit_go;
    logic i_last;
    logic j_last;
    logic bad_any;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/ocix_ctrl.sv =====
// Sequencer for the order coordinate index unit
`default_nettype none
module ocix_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ocix_pkg::stat_t stat_i,
  output ocix_pkg::cmd_e  cmd_o
);
  import ocix_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP_RST;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = C_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ST_SWEEP_RST: begin
        cmd_o = C_SWEEP;
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_SWEEP_CLR: begin
        cmd_o = C_SWEEP;
        if (stat_i.sweep_last) state_d = ST_DONE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o   = C_ACCEPT;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o = C_EXEC;
        if (stat_i.is_clear) state_d = ST_SWEEP_CLR;
        else if (stat_i.commit_go) state_d = ST_GATH_A;
        else state_d = ST_DONE;
      end
      ST_GATH_A: begin
        cmd_o   = C_GATH_A;
        state_d = ST_GATH_B;
      end
      ST_GATH_B: begin
        cmd_o   = C_GATH_B;
        state_d = ST_GATH_C;
      end
      ST_GATH_C: begin
        cmd_o = C_GATH_C;
        if (!stat_i.i_last) state_d = ST_GATH_A;
        else if (stat_i.bad_any) state_d = ST_DONE;
        else state_d = ST_LOAD_A;
      end
      ST_LOAD_A: begin
        cmd_o   = C_LOAD_A;
        state_d = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        cmd_o   = C_LOAD_B;
        state_d = ST_CNT_A;
      end
      ST_CNT_A: begin
        cmd_o   = C_CNT_A;
        state_d = ST_CNT_B;
      end
      ST_CNT_B: begin
        cmd_o   = C_CNT_B;
        state_d = stat_i.j_last ? ST_PLACE : ST_CNT_A;
      end
      ST_PLACE: begin
        cmd_o   = C_PLACE;
        state_d = stat_i.i_last ? ST_WR_A : ST_LOAD_A;
      end
      ST_WR_A: begin
        cmd_o   = C_WR_A;
        state_d = ST_WR_B;
      end
      ST_WR_B: begin
        cmd_o   = C_WR_B;
        state_d = stat_i.i_last ? ST_DONE : ST_WR_A;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o   = C_EMIT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ocix_dp.sv =====
// Datapath: coordinate tables, permute buffer, ranking scratch and result register
`default_nettype none
module ocix_dp #(
  parameter int VERTICES  = 1024,
  parameter int DELTA_MAX = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ocix_pkg::cmd_e  cmd_i,
  output ocix_pkg::stat_t stat_o,
  input  ocix_pkg::req_t  in_data_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output ocix_pkg::rsp_t  out_data_o
);
  import ocix_pkg::*;

  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int DW = $clog2(DELTA_MAX);
  localparam int CW = $clog2(DELTA_MAX + 1);

  // storage
  logic [63:0]   xmem [VERTICES];
  logic [63:0]   ymem [VERTICES];
  logic [1:0]    vmem [VERTICES];   // [0] x present, [1] y present
  dent_t         dmem [DELTA_MAX];
  logic [63:0]   txm  [DELTA_MAX];
  logic [63:0]   tym  [DELTA_MAX];
  logic [63:0]   sxm  [DELTA_MAX];
  logic [63:0]   sym  [DELTA_MAX];
  logic [VW-1:0] xvm  [DELTA_MAX];
  logic [VW-1:0] yvm  [DELTA_MAX];

  req_t          req_q;
  logic [VW-1:0] sweep_q;
  logic [CW-1:0] cnt_q, i_q, j_q;
  logic [CW-1:0] xp_q, yp_q, xrp_q, yrp_q;
  logic          err_q, bad_q;
  logic [63:0]   top_q, bot_q, ly_q;
  dent_t         ent_q, drd_q;
  logic [63:0]   vx_q, vy_q;
  logic [63:0]   xrd_q, yrd_q, txrd_q, tyrd_q, sxrd_q, syrd_q;
  logic [1:0]    vrd_q;
  logic [VW-1:0] xvrd_q, yvrd_q;
  rsp_t          res_q, res_d, out_q;
  logic          ov_q;

  logic          in_rng, d_rng, full, commit_go, bad_now, i_last, j_last;
  logic [VW-1:0] vidx, dvidx, tab_ra;
  logic          tab_re, d_re;
  logic [DW-1:0] d_ra;
  logic          xwe, ywe, vwe;
  logic [VW-1:0] xwa, ywa, vwa;
  logic [63:0]   xwd, ywd;
  logic [1:0]    vwd;
  logic          x_less, y_less, xr_less, yr_less, j_before;

  assign vidx      = VW'(req_q.vertex);
  assign dvidx     = VW'(drd_q.vertex);
  assign in_rng    = 32'(req_q.vertex) < 32'(VERTICES);
  assign d_rng     = 32'(drd_q.vertex) < 32'(VERTICES);
  assign full      = cnt_q == CW'(DELTA_MAX);
  assign commit_go = (req_q.req_type == REQ_PERMUTE) && req_q.last && !full && !err_q;
  assign bad_now   = !d_rng || !vrd_q[0] || !vrd_q[1];
  assign i_last    = i_q == cnt_q - 1'b1;
  assign j_last    = j_q == cnt_q - 1'b1;

  assign stat_o.sweep_last = sweep_q == VW'(VERTICES - 1);
  assign stat_o.is_clear   = req_q.req_type == REQ_CLEAR;
  assign stat_o.commit_go  = commit_go;
  assign stat_o.i_last     = i_last;
  assign stat_o.j_last     = j_last;
  assign stat_o.bad_any    = bad_q || bad_now;
  assign stat_o.out_free   = !ov_q || !out_stall_i;

  assign tab_re = (cmd_i == C_ACCEPT) || (cmd_i == C_GATH_B);
  assign tab_ra = (cmd_i == C_ACCEPT) ? VW'(in_data_i.vertex) : dvidx;
  assign d_re   = (cmd_i == C_GATH_A) || (cmd_i == C_LOAD_A) || (cmd_i == C_CNT_A);
  assign d_ra   = (cmd_i == C_CNT_A) ? j_q[DW-1:0] : i_q[DW-1:0];

  // ranking compares: stable, earlier arrival wins a tie
  assign j_before = j_q < i_q;
  assign x_less   = ($signed(txrd_q) < $signed(vx_q)) || ((txrd_q == vx_q) && j_before);
  assign y_less   = ($signed(tyrd_q) < $signed(vy_q)) || ((tyrd_q == vy_q) && j_before);
  assign xr_less  = (drd_q.x_rank < ent_q.x_rank) ||
                    ((drd_q.x_rank == ent_q.x_rank) && j_before);
  assign yr_less  = (drd_q.y_rank < ent_q.y_rank) ||
                    ((drd_q.y_rank == ent_q.y_rank) && j_before);

  // table write selection
  always_comb begin
    xwe = 1'b0; xwa = vidx; xwd = top_q;
    ywe = 1'b0; ywa = vidx; ywd = bot_q - 64'd1;
    vwe = 1'b0; vwa = vidx; vwd = 2'b00;
    case (cmd_i)
      C_SWEEP: begin
        vwe = 1'b1;
        vwa = sweep_q;
      end
      C_EXEC: begin
        if (in_rng) begin
          case (req_q.req_type)
            REQ_APPEND: begin
              xwe = 1'b1; ywe = 1'b1; vwe = 1'b1; vwd = 2'b11;
            end
            REQ_REMOVE: vwe = 1'b1;
            REQ_LOAD_X: begin
              xwe = 1'b1; vwe = 1'b1; vwd = {vrd_q[1], 1'b1};
            end
            REQ_LOAD_Y: begin
              ywe = 1'b1; ywd = ly_q; vwe = 1'b1; vwd = {1'b1, vrd_q[0]};
            end
            default: ;
          endcase
        end
      end
      C_WR_B: begin
        xwe = 1'b1; xwa = xvrd_q; xwd = sxrd_q;
        ywe = 1'b1; ywa = yvrd_q; ywd = syrd_q;
      end
      default: ;
    endcase
  end

  // immediate result of a request
  always_comb begin
    res_d = '0;
    case (req_q.req_type)
      REQ_APPEND, REQ_REMOVE, REQ_LOAD_X, REQ_LOAD_Y: begin
        if (!in_rng) res_d.status = STS_MISSING;
      end
      REQ_LOOKUP: begin
        if (!in_rng) begin
          res_d.status = STS_MISSING;
        end else begin
          res_d.x_present = vrd_q[0];
          res_d.y_present = vrd_q[1];
          res_d.x_value   = vrd_q[0] ? xrd_q : 64'd0;
          res_d.y_value   = vrd_q[1] ? yrd_q : 64'd0;
        end
      end
      REQ_PERMUTE: begin
        if (full || (req_q.last && err_q)) res_d.status = STS_OVERFLOW;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (xwe) xmem[xwa] <= xwd;
    if (ywe) ymem[ywa] <= ywd;
    if (vwe) vmem[vwa] <= vwd;
    if (tab_re) begin
      xrd_q <= xmem[tab_ra];
      yrd_q <= ymem[tab_ra];
      vrd_q <= vmem[tab_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == C_EXEC && req_q.req_type == REQ_PERMUTE && !full) begin
      dmem[cnt_q[DW-1:0]] <= '{vertex: req_q.vertex, x_rank: req_q.x_rank,
                               y_rank: req_q.y_rank};
    end
    if (cmd_i == C_GATH_C) begin
      txm[i_q[DW-1:0]] <= xrd_q;
      tym[i_q[DW-1:0]] <= yrd_q;
    end
    if (d_re) begin
      drd_q  <= dmem[d_ra];
      txrd_q <= txm[d_ra];
      tyrd_q <= tym[d_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == C_PLACE) begin
      sxm[xp_q[DW-1:0]]  <= vx_q;
      sym[yp_q[DW-1:0]]  <= vy_q;
      xvm[xrp_q[DW-1:0]] <= VW'(ent_q.vertex);
      yvm[yrp_q[DW-1:0]] <= VW'(ent_q.vertex);
    end
    if (cmd_i == C_WR_A) begin
      sxrd_q <= sxm[i_q[DW-1:0]];
      syrd_q <= sym[i_q[DW-1:0]];
      xvrd_q <= xvm[i_q[DW-1:0]];
      yvrd_q <= yvm[i_q[DW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i == C_ACCEPT) req_q <= in_data_i;
    if (cmd_i == C_EXEC) res_q <= res_d;
    if (cmd_i == C_GATH_C && i_last && (bad_q || bad_now)) res_q.status <= STS_MISSING;
    if (cmd_i == C_LOAD_B) begin
      ent_q <= drd_q;
      vx_q  <= txrd_q;
      vy_q  <= tyrd_q;
    end
    if (cmd_i == C_EMIT) out_q <= res_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      bad_q   <= 1'b0;
      top_q   <= '0;
      bot_q   <= '0;
      ly_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      xp_q    <= '0;
      yp_q    <= '0;
      xrp_q   <= '0;
      yrp_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      case (cmd_i)
        C_SWEEP: sweep_q <= stat_o.sweep_last ? '0 : sweep_q + 1'b1;
        C_EXEC: begin
          i_q   <= '0;
          bad_q <= 1'b0;
          case (req_q.req_type)
            REQ_CLEAR: begin
              top_q <= '0; bot_q <= '0; ly_q <= '0;
            end
            REQ_APPEND: begin
              if (in_rng) begin
                top_q <= top_q + 64'd1;
                bot_q <= bot_q - 64'd1;
              end
            end
            REQ_LOAD_X: if (in_rng) top_q <= top_q + 64'd1;
            REQ_LOAD_Y: if (in_rng) ly_q <= ly_q + 64'd1;
            REQ_PERMUTE: begin
              if (req_q.last && !commit_go) begin
                cnt_q <= '0;
                err_q <= 1'b0;
              end else if (full) begin
                err_q <= 1'b1;
              end else begin
                cnt_q <= cnt_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
        C_GATH_C: begin
          i_q   <= i_last ? '0 : i_q + 1'b1;
          bad_q <= bad_q || bad_now;
          if (i_last && (bad_q || bad_now)) begin
            cnt_q <= '0;
            err_q <= 1'b0;
          end
        end
        C_LOAD_B: begin
          j_q <= '0; xp_q <= '0; yp_q <= '0; xrp_q <= '0; yrp_q <= '0;
        end
        C_CNT_B: begin
          j_q <= j_q + 1'b1;
          if (x_less)  xp_q  <= xp_q + 1'b1;
          if (y_less)  yp_q  <= yp_q + 1'b1;
          if (xr_less) xrp_q <= xrp_q + 1'b1;
          if (yr_less) yrp_q <= yrp_q + 1'b1;
        end
        C_PLACE: i_q <= i_last ? '0 : i_q + 1'b1;
        C_WR_B: begin
          i_q <= i_q + 1'b1;
          if (i_last) begin
            cnt_q <= '0;
            err_q <= 1'b0;
          end
        end
        default: ;
      endcase
      if (cmd_i == C_EMIT) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== design/order_coordinate_index_unit.sv =====
// Top level of the order coordinate index unit
// Append, remove, load and lookup pass from input transfer to result through accept,
//   table read-modify-write and result register; one item at a time.
// Clear adds a sweep over the present bits.
// Permute commit with n buffered elements gathers their coordinates, ranks them by a
//   pairwise count that walks the buffer memory once per element, and writes them back.
// Reset: counters, buffer fill and error clear at once; a sweep then clears the
//   present-bit memory, with input stalled throughout.
`default_nettype none
module order_coordinate_index_unit #(
  parameter int VERTICES  = 1024,
  parameter int DELTA_MAX = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ocix_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ocix_pkg::rsp_t out_data_o
);
  import ocix_pkg::*;

  cmd_e  cmd;     // per-cycle command from sequencer
  stat_t stat;    // datapath status back to sequencer

  ocix_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // result register in the datapath parts the output transfer from the next input
  ocix_dp #(
    .VERTICES  (VERTICES),
    .DELTA_MAX (DELTA_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
